/* sv/bra_pkg.sv */
// Shared types and constants for the bit-set range store.
// No dependencies; every other file but bra_ram imports this package.
`default_nettype none

package bra_pkg;

    // Widths of the request index fields.
    localparam int IDX_W  = 17;
    localparam int BYTE_W = IDX_W - 3;

    // Request kinds.
    typedef logic [1:0] t_req;
    localparam t_req REQ_CLEAR = 2'd0;
    localparam t_req REQ_GET   = 2'd1;
    localparam t_req REQ_SET   = 2'd2;
    localparam t_req REQ_ANY   = 2'd3;

    // Answer kinds.
    localparam logic ANS_GET = 1'b0;
    localparam logic ANS_ANY = 1'b1;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        t_req              op;
        logic              zero;        // answer is 0 without touching the store
        logic [2:0]        pos;         // bit position within the byte
        logic              val;         // value written by a set
        logic [BYTE_W-1:0] first_byte;  // target byte, or first byte of a walk
        logic [BYTE_W-1:0] last_byte;   // last byte of a walk
        logic [7:0]        first_mask;  // valid bits of the first byte of a range
        logic [7:0]        last_mask;   // valid bits of the last byte of a range
    } t_cmd;

endpackage

`default_nettype wire

/* sv/bra_if.sv */
// Valid/ready channel interfaces for requests and answers.
// Depends on bra_pkg for field widths and kinds.
`default_nettype none

interface bra_req_if import bra_pkg::*; ();
    logic             valid;
    logic             ready;
    t_req             req_type;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] range_end;
    logic             bit_value;

    modport source (output valid, req_type, first_index, range_end, bit_value,
                    input ready);
    modport sink   (input valid, req_type, first_index, range_end, bit_value,
                    output ready);
endinterface

interface bra_ans_if;
    logic valid;
    logic ready;
    logic answer_kind;
    logic answer_bit;

    modport source (output valid, answer_kind, answer_bit, input ready);
    modport sink   (input valid, answer_kind, answer_bit, output ready);
endinterface

`default_nettype wire

/* sv/bra_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module bra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/bra_front.sv */
// Front end: accepts request beats, clips indices and classifies them into commands.
// Depends on bra_pkg and bra_req_if.
`default_nettype none

module bra_front import bra_pkg::*; #(
    parameter int NUM_BITS = 65536
) (
    bra_req_if.sink    i_req,
    input  wire logic  i_busy,
    input  wire logic  i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam int STORE_BYTES = (NUM_BITS + 7) / 8;

    logic             idx_in;
    logic             end_in;
    logic [IDX_W-1:0] lo_c;
    logic [IDX_W-1:0] hi_c;
    logic [IDX_W-1:0] hi_m1;

    // Clip both bounds to the size of the store.
    always_comb begin
        idx_in = 32'(i_req.first_index) < 32'(NUM_BITS);
        end_in = 32'(i_req.range_end) < 32'(NUM_BITS);
        lo_c   = idx_in ? i_req.first_index : IDX_W'(NUM_BITS);
        hi_c   = end_in ? i_req.range_end : IDX_W'(NUM_BITS);
        hi_m1  = hi_c - IDX_W'(1);
    end

    // Classify the request.
    always_comb begin
        o_cmd            = '0;
        o_cmd.op         = i_req.req_type;
        o_cmd.val        = i_req.bit_value;
        o_cmd.pos        = i_req.first_index[2:0];
        o_cmd.first_byte = i_req.first_index[IDX_W-1:3];
        o_cmd.first_mask = 8'hFF;
        o_cmd.last_mask  = 8'hFF;
        unique case (i_req.req_type)
            REQ_CLEAR: begin
                // A clear past the end stops at the last byte of the store.
                if (32'(i_req.first_index[IDX_W-1:3]) > 32'(STORE_BYTES - 1)) begin
                    o_cmd.last_byte = BYTE_W'(STORE_BYTES - 1);
                end else begin
                    o_cmd.last_byte = i_req.first_index[IDX_W-1:3];
                end
            end
            REQ_GET: begin
                o_cmd.zero = !idx_in;
            end
            REQ_SET: begin
                o_cmd.zero = !idx_in;
            end
            REQ_ANY: begin
                o_cmd.zero       = lo_c >= hi_c;
                o_cmd.first_byte = lo_c[IDX_W-1:3];
                o_cmd.last_byte  = hi_m1[IDX_W-1:3];
                o_cmd.first_mask = 8'hFF << lo_c[2:0];
                o_cmd.last_mask  = 8'hFF >> (3'd7 - hi_m1[2:0]);
            end
        endcase
    end

    // Handshake; a set outside the store is taken and dropped.
    assign i_req.ready = !i_busy && !i_q_full;
    assign o_push      = i_req.valid && i_req.ready &&
                         !(i_req.req_type == REQ_SET && !idx_in);

endmodule

`default_nettype wire

/* sv/bra_cmdq.sv */
// Two-entry command queue between the front end and the back end.
// Depends on bra_pkg.
`default_nettype none

module bra_cmdq import bra_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_nempty,
    output t_cmd      o_head
);

    t_cmd       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_cmd;
        end
    end

    assign o_full   = r_cnt == 2'd2;
    assign o_nempty = r_cnt != 2'd0;
    assign o_head   = r_ent[r_rp];

endmodule

`default_nettype wire

/* sv/bra_back.sv */
// Back end: executes commands against the byte store and registers the answers.
// Depends on bra_pkg, bra_ans_if and bra_ram.
`default_nettype none

module bra_back import bra_pkg::*; #(
    parameter int NUM_BITS = 65536
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cmd_valid,
    input  wire t_cmd  i_cmd,
    output logic       o_pop,
    output logic       o_busy,
    bra_ans_if.source  o_ans
);

    localparam int STORE_BYTES = (NUM_BITS + 7) / 8;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CLR   = 3'd2;
    localparam logic [2:0] S_GETRD = 3'd3;
    localparam logic [2:0] S_SETRD = 3'd4;
    localparam logic [2:0] S_ANY   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [BYTE_W-1:0] b);
        logic [31:0] w;
        w = 32'(b);
        return w[ADDR_W-1:0];
    endfunction

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_addr,  n_addr;
    logic              r_more,  n_more;
    logic              r_pend,  n_pend;
    logic              r_pf,    n_pf;
    logic              r_pl,    n_pl;
    logic              r_ans,   n_ans;
    t_cmd              r_cmd,   n_cmd;
    logic              r_ovalid, n_ovalid;
    logic              r_okind,  n_okind;
    logic              r_obit,   n_obit;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic [7:0]        bit_mask;
    logic [7:0]        rng_mask;
    logic              hit;

    bra_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Masks for the byte that just came back from the store.
    always_comb begin
        bit_mask = 8'd1 << r_cmd.pos;
        rng_mask = 8'hFF;
        if (r_pf) begin
            rng_mask = rng_mask & r_cmd.first_mask;
        end
        if (r_pl) begin
            rng_mask = rng_mask & r_cmd.last_mask;
        end
        hit = |(ram_rdata & rng_mask);
    end

    // Sequencer.
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_more    = r_more;
        n_pend    = 1'b0;
        n_pf      = r_pf;
        n_pl      = r_pl;
        n_ans     = r_ans;
        n_cmd     = r_cmd;
        n_ovalid  = r_ovalid && !o_ans.ready;
        n_okind   = r_okind;
        n_obit    = r_obit;
        o_pop     = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_addr;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = 8'd0;
        unique case (r_state)
            S_SWEEP: begin
                // Zero the whole store once after reset.
                ram_we = 1'b1;
                if (r_addr == ADDR_W'(STORE_BYTES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop  = 1'b1;
                    n_cmd  = i_cmd;
                    n_addr = to_addr(i_cmd.first_byte);
                    unique case (i_cmd.op)
                        REQ_CLEAR: begin
                            n_addr  = '0;
                            n_state = S_CLR;
                        end
                        REQ_GET: begin
                            if (i_cmd.zero) begin
                                n_ans   = 1'b0;
                                n_state = S_EMIT;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = to_addr(i_cmd.first_byte);
                                n_state   = S_GETRD;
                            end
                        end
                        REQ_SET: begin
                            ram_re    = 1'b1;
                            ram_raddr = to_addr(i_cmd.first_byte);
                            n_state   = S_SETRD;
                        end
                        REQ_ANY: begin
                            if (i_cmd.zero) begin
                                n_ans   = 1'b0;
                                n_state = S_EMIT;
                            end else begin
                                n_more  = 1'b1;
                                n_state = S_ANY;
                            end
                        end
                    endcase
                end
            end
            S_CLR: begin
                // Zero bytes from the start up to the last byte of the clear.
                ram_we = 1'b1;
                if (r_addr == to_addr(r_cmd.last_byte)) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            S_GETRD: begin
                n_ans   = ram_rdata[r_cmd.pos];
                n_state = S_EMIT;
            end
            S_SETRD: begin
                // Read-modify-write of the addressed byte.
                ram_we = 1'b1;
                if (r_cmd.val) begin
                    ram_wdata = ram_rdata | bit_mask;
                end else begin
                    ram_wdata = ram_rdata & ~bit_mask;
                end
                n_state = S_IDLE;
            end
            S_ANY: begin
                // Issue one byte read a cycle and test the byte read the cycle before.
                if (r_more) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_addr;
                    n_pend    = 1'b1;
                    n_pf      = r_addr == to_addr(r_cmd.first_byte);
                    n_pl      = r_addr == to_addr(r_cmd.last_byte);
                    n_more    = r_addr != to_addr(r_cmd.last_byte);
                    n_addr    = r_addr + ADDR_W'(1);
                end
                if (r_pend) begin
                    if (hit) begin
                        n_ans   = 1'b1;
                        n_state = S_EMIT;
                    end else if (r_pl) begin
                        n_ans   = 1'b0;
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (!r_ovalid || o_ans.ready) begin
                    n_ovalid = 1'b1;
                    n_okind  = (r_cmd.op == REQ_ANY) ? ANS_ANY : ANS_GET;
                    n_obit   = r_ans;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_addr   <= '0;
            r_more   <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_more   <= n_more;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pf    <= n_pf;
        r_pl    <= n_pl;
        r_ans   <= n_ans;
        r_cmd   <= n_cmd;
        r_okind <= n_okind;
        r_obit  <= n_obit;
    end

    assign o_busy            = r_state == S_SWEEP;
    assign o_ans.valid       = r_ovalid;
    assign o_ans.answer_kind = r_okind;
    assign o_ans.answer_bit  = r_obit;

endmodule

`default_nettype wire

/* sv/bitset_range_any_store.sv */
// Bit-set store with clear-prefix, get, set and any-in-range requests.
// An any walks the bytes of its range, one read a cycle, stopping at the first hit; a get
// outside the store or an empty range is answered without reading the store.
// Executor: a set is a read-modify-write of one byte; a clear zeroes bytes up to its last.
// Reset: synchronous; afterwards a sweep zeroes the store, one byte a cycle over
// (NUM_BITS+7)/8 bytes, 8192 by default, and no request is taken until it ends.
`default_nettype none

module bitset_range_any_store import bra_pkg::*; #(
    parameter int NUM_BITS = 65536
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bra_req_if.sink   i_req,
    bra_ans_if.source o_ans
);

    logic busy;
    logic q_full;
    logic q_nempty;
    logic push;
    logic pop;
    t_cmd cmd_in;
    t_cmd cmd_head;

    // Classify incoming requests.
    bra_front #(
        .NUM_BITS (NUM_BITS)
    ) u_front (
        .i_req    (i_req),
        .i_busy   (busy),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (cmd_in)
    );

    // Decouple the front end from the executor.
    bra_cmdq u_cmdq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (cmd_in),
        .i_pop    (pop),
        .o_full   (q_full),
        .o_nempty (q_nempty),
        .o_head   (cmd_head)
    );

    // Execute commands against the store.
    bra_back #(
        .NUM_BITS (NUM_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_nempty),
        .i_cmd       (cmd_head),
        .o_pop       (pop),
        .o_busy      (busy),
        .o_ans       (o_ans)
    );

    // The store sweep starts right after reset.
    a_sweep_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("store sweep did not start after reset");

    // No request beat is taken while the store is being swept.
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !(i_req.valid && i_req.ready))
        else $error("request taken during store sweep");

    // The queue is never written when full.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("command pushed into a full queue");

    // The executor only pops a queue that holds a command.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_nempty)
        else $error("command popped from an empty queue");

endmodule

`default_nettype wire
